### rtl/c_nls_pkg.sv
// ----------------------------------------------------------------------------
// C numeric literal scanner package
// Shared phase and status codes, state and result types, character classes.
// ----------------------------------------------------------------------------
`default_nettype none

package c_nls_pkg;

  localparam int LENGTH_BITS = 8;
  localparam logic [7:0] LEN_CAP = (LENGTH_BITS >= 8) ? 8'd255 :
                                   8'((1 << LENGTH_BITS) - 1);

  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_FIRST_ZERO   = 4'd1;
  localparam logic [3:0] PH_INT          = 4'd2;
  localparam logic [3:0] PH_INT_SUFFIX   = 4'd3;
  localparam logic [3:0] PH_FRAC         = 4'd4;
  localparam logic [3:0] PH_EXP_START    = 4'd5;
  localparam logic [3:0] PH_EXP_SIGN     = 4'd6;
  localparam logic [3:0] PH_EXP_DIGITS   = 4'd7;
  localparam logic [3:0] PH_EXP_BAD      = 4'd8;
  localparam logic [3:0] PH_HEX_NOEXP    = 4'd9;
  localparam logic [3:0] PH_FLOAT_SUFFIX = 4'd10;

  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_INTEGER    = 3'd1;
  localparam logic [2:0] ST_FLOATING   = 3'd2;
  localparam logic [2:0] ST_BAD_SUFFIX = 3'd3;
  localparam logic [2:0] ST_EMPTY_EXP  = 3'd4;
  localparam logic [2:0] ST_BAD_OCTAL  = 3'd5;
  localparam logic [2:0] ST_HEX_NO_EXP = 3'd6;

  localparam logic [1:0] LONG_NONE     = 2'd0;
  localparam logic [1:0] LONG_LOWER    = 2'd1;
  localparam logic [1:0] LONG_UPPER    = 2'd2;
  localparam logic [1:0] LONG_CLOSED   = 2'd3;

  typedef struct packed {
    logic [3:0] phase;
    logic       hex_mode;
    logic       leading_zero;
    logic       non_octal_seen;
    logic       fraction_seen;
    logic       unsigned_mark;
    logic [1:0] long_mark;
    logic       float_mark;
    logic       suffix_bad;
    logic [7:0] char_count;
  } scan_state_t;

  typedef struct packed {
    logic       consumed;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] length;
  } scan_result_t;

  localparam scan_state_t SCAN_STATE_RESET = '{phase: PH_IDLE, long_mark: LONG_NONE,
                                               char_count: 8'd0, default: 1'b0};

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_dec(c) || is_alpha(c);
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

endpackage

`default_nettype wire

### rtl/c_nls_in_if.sv
// ----------------------------------------------------------------------------
// Scanner input channel
// Valid/ready channel carrying one source byte and its control flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface c_nls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       start_req;
  logic       end_of_input;

  modport source (output valid, ch, start_req, end_of_input, input ready);
  modport sink   (input valid, ch, start_req, end_of_input, output ready);
endinterface

`default_nettype wire

### rtl/c_nls_out_if.sv
// ----------------------------------------------------------------------------
// Scanner result channel
// Valid/ready channel carrying one result per input byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface c_nls_out_if;
  logic       valid;
  logic       ready;
  logic       consumed;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] length;

  modport source (output valid, consumed, done_res, status, length, input ready);
  modport sink   (input valid, consumed, done_res, status, length, output ready);
endinterface

`default_nettype wire

### rtl/c_nls_step.sv
// ----------------------------------------------------------------------------
// Scanner step logic
// Combinational next state and result for one byte against the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module c_nls_step
  import c_nls_pkg::*;
(
  input  scan_state_t  cur,
  input  logic [7:0]   ch,
  input  logic         start_req,
  input  logic         end_of_input,
  output scan_state_t  nxt,
  output scan_result_t res
);

  function automatic scan_state_t int_suffix(input scan_state_t st, input logic [7:0] c);
    scan_state_t r;
    r = st;
    if ((c == "u") || (c == "U")) begin
      if (st.unsigned_mark) r.suffix_bad = 1'b1;
      r.unsigned_mark = 1'b1;
      if ((st.long_mark == LONG_LOWER) || (st.long_mark == LONG_UPPER)) begin
        r.long_mark = LONG_CLOSED;
      end
    end else if (c == "l") begin
      if (st.long_mark == LONG_NONE) r.long_mark = LONG_LOWER;
      else if (st.long_mark == LONG_LOWER) r.long_mark = LONG_CLOSED;
      else r.suffix_bad = 1'b1;
    end else if (c == "L") begin
      if (st.long_mark == LONG_NONE) r.long_mark = LONG_UPPER;
      else if (st.long_mark == LONG_UPPER) r.long_mark = LONG_CLOSED;
      else r.suffix_bad = 1'b1;
    end else begin
      r.suffix_bad = 1'b1;
    end
    return r;
  endfunction

  function automatic scan_state_t float_suffix(input scan_state_t st, input logic [7:0] c);
    scan_state_t r;
    r = st;
    if ((c == "f") || (c == "F") || (c == "l") || (c == "L")) begin
      if (st.float_mark) r.suffix_bad = 1'b1;
      r.float_mark = 1'b1;
    end else begin
      r.suffix_bad = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [2:0] close_status(input scan_state_t st);
    logic [2:0] r;
    case (st.phase)
      PH_FIRST_ZERO, PH_INT: begin
        r = (st.leading_zero && !st.hex_mode && st.non_octal_seen) ? ST_BAD_OCTAL : ST_INTEGER;
      end
      PH_INT_SUFFIX:   r = st.suffix_bad ? ST_BAD_SUFFIX : ST_INTEGER;
      PH_FRAC:         r = st.hex_mode ? ST_HEX_NO_EXP : ST_FLOATING;
      PH_EXP_START, PH_EXP_SIGN, PH_EXP_BAD: r = ST_EMPTY_EXP;
      PH_EXP_DIGITS:   r = ST_FLOATING;
      PH_HEX_NOEXP:    r = ST_HEX_NO_EXP;
      PH_FLOAT_SUFFIX: r = st.suffix_bad ? ST_BAD_SUFFIX : ST_FLOATING;
      default:         r = ST_BUSY;
    endcase
    return r;
  endfunction

  scan_state_t s;
  scan_state_t adv;
  logic        take;
  logic        close;
  logic        digit_mode;
  logic        exp_mark;
  logic [3:0]  ph;
  logic [7:0]  count_next;

  always_comb begin
    s          = start_req ? SCAN_STATE_RESET : cur;
    adv        = s;
    take       = 1'b0;
    close      = 1'b0;
    ph         = s.phase;
    digit_mode = s.hex_mode ? is_hexd(ch) : is_dec(ch);
    exp_mark   = s.hex_mode ? ((ch == "p") || (ch == "P")) : ((ch == "e") || (ch == "E"));

    if (end_of_input) begin
      close = (s.phase != PH_IDLE);
    end else if (s.phase == PH_IDLE) begin
      if (start_req) begin
        if (ch == "0") begin
          adv.phase        = PH_FIRST_ZERO;
          adv.leading_zero = 1'b1;
          take             = 1'b1;
        end else if (is_dec(ch)) begin
          adv.phase = PH_INT;
          take      = 1'b1;
        end else if (ch == ".") begin
          adv.phase = PH_FRAC;
          take      = 1'b1;
        end
      end
    end else if ((s.phase == PH_FIRST_ZERO) && ((ch == "x") || (ch == "X"))) begin
      adv.hex_mode = 1'b1;
      adv.phase    = PH_INT;
      take         = 1'b1;
    end else begin
      if (ph == PH_FIRST_ZERO) begin
        ph        = PH_INT;
        adv.phase = PH_INT;
      end
      case (ph)
        PH_INT: begin
          if (digit_mode) begin
            if (!s.hex_mode && ((ch == "8") || (ch == "9"))) adv.non_octal_seen = 1'b1;
            take = 1'b1;
          end else if (ch == ".") begin
            adv.phase = PH_FRAC;
            take      = 1'b1;
          end else if (exp_mark) begin
            adv.phase = PH_EXP_START;
            take      = 1'b1;
          end else if (!(s.leading_zero && !s.hex_mode && s.non_octal_seen) && is_alpha(ch)) begin
            adv       = int_suffix(adv, ch);
            adv.phase = PH_INT_SUFFIX;
            take      = 1'b1;
          end
        end
        PH_INT_SUFFIX: begin
          if (is_alpha(ch)) begin
            adv  = int_suffix(adv, ch);
            take = 1'b1;
          end
        end
        PH_FRAC: begin
          if (digit_mode) begin
            adv.fraction_seen = 1'b1;
            take              = 1'b1;
          end else if (exp_mark) begin
            adv.phase = PH_EXP_START;
            take      = 1'b1;
          end else if (s.hex_mode) begin
            if (is_alnum(ch)) begin
              adv.phase = PH_HEX_NOEXP;
              take      = 1'b1;
            end
          end else if (is_alpha(ch)) begin
            adv       = float_suffix(adv, ch);
            adv.phase = PH_FLOAT_SUFFIX;
            take      = 1'b1;
          end
        end
        PH_EXP_START, PH_EXP_SIGN: begin
          if ((ph == PH_EXP_START) && ((ch == "+") || (ch == "-"))) begin
            adv.phase = PH_EXP_SIGN;
            take      = 1'b1;
          end else if (is_dec(ch)) begin
            adv.phase = PH_EXP_DIGITS;
            take      = 1'b1;
          end else if (is_alnum(ch)) begin
            adv.phase = PH_EXP_BAD;
            take      = 1'b1;
          end
        end
        PH_EXP_DIGITS: begin
          if (is_dec(ch)) begin
            take = 1'b1;
          end else if (is_alpha(ch)) begin
            adv       = float_suffix(adv, ch);
            adv.phase = PH_FLOAT_SUFFIX;
            take      = 1'b1;
          end
        end
        PH_EXP_BAD, PH_HEX_NOEXP: begin
          take = is_alnum(ch);
        end
        PH_FLOAT_SUFFIX: begin
          if (is_alpha(ch)) begin
            adv  = float_suffix(adv, ch);
            take = 1'b1;
          end
        end
        default: begin
          take = 1'b0;
        end
      endcase
      close = !take;
    end

    count_next = (s.char_count < LEN_CAP) ? (s.char_count + 8'd1) : s.char_count;

    res = '0;
    nxt = s;
    if (take) begin
      nxt            = adv;
      nxt.char_count = count_next;
      res.consumed   = 1'b1;
      res.length     = count_next;
    end else if (close) begin
      nxt          = SCAN_STATE_RESET;
      res.done_res = 1'b1;
      res.status   = close_status(s);
      res.length   = s.char_count;
    end
  end

endmodule

`default_nettype wire

### rtl/c_number_literal_scanner.sv
// ----------------------------------------------------------------------------
// C number literal scanner
// Scans one C numeric literal from a byte stream with one byte of lookahead.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on scan_in, one transaction per byte, with start_req
// marking the first byte of a literal and end_of_input closing it. Every
// input transaction yields exactly one result transaction on scan_out: the
// consumed flag, the done flag, a status code and the running length.
// The byte is captured in the input register as it is accepted, and the
// step logic then loads the result register from it once that register
// is free; the result is presented from the result register. Throughput
// is one byte per cycle while the receiver takes every result, set by the
// scan state loop, which updates through the step logic as each result is
// loaded.
// Reset clears the scan state and empties both registers; no result is
// presented until a new byte has been accepted.
// When the receiver stalls, the result register holds its transaction, the
// input register fills, and scan_in.ready falls until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module c_number_literal_scanner
  import c_nls_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  c_nls_in_if.sink     scan_in,
  c_nls_out_if.source  scan_out
);

  logic         in_valid;
  logic [7:0]   in_ch;
  logic         in_start;
  logic         in_eoi;
  scan_state_t  state;
  scan_state_t  state_next;
  scan_result_t step_res;
  logic         out_valid;
  scan_result_t out_res;
  logic         out_free;
  logic         in_move;

  assign out_free      = !out_valid || scan_out.ready;
  assign in_move       = in_valid && out_free;
  assign scan_in.ready = !in_valid || out_free;

  c_nls_step u_step (
    .cur          (state),
    .ch           (in_ch),
    .start_req    (in_start),
    .end_of_input (in_eoi),
    .nxt          (state_next),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= SCAN_STATE_RESET;
    end else begin
      if (scan_in.valid && scan_in.ready) begin
        in_valid <= 1'b1;
      end else if (in_move) begin
        in_valid <= 1'b0;
      end
      if (in_move) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (scan_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_in.valid && scan_in.ready) begin
      in_ch    <= scan_in.ch;
      in_start <= scan_in.start_req;
      in_eoi   <= scan_in.end_of_input;
    end
    if (in_move) begin
      out_res <= step_res;
    end
  end

  assign scan_out.valid    = out_valid;
  assign scan_out.consumed = out_res.consumed;
  assign scan_out.done_res = out_res.done_res;
  assign scan_out.status   = out_res.status;
  assign scan_out.length   = out_res.length;

endmodule

`default_nettype wire

### rtl/c_nls_checker.sv
// ----------------------------------------------------------------------------
// Scanner port checker
// Concurrent checks on the ports of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module c_nls_checker
  import c_nls_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire       consumed,
  input wire       done_res,
  input wire [2:0] status,
  input wire [7:0] length
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({consumed, done_res, status, length}))
    else $error("Stalled result changed or was dropped.");

  a_close_not_consumed: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !consumed && (status != ST_BUSY))
    else $error("A closing byte was reported as consumed or without a status.");

  a_busy_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> (status == ST_BUSY))
    else $error("A status was reported while the literal continued.");

  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res && !consumed |-> (length == 8'd0))
    else $error("An ignored byte reported a non-zero length.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("A result was presented straight after reset.");

endmodule

bind c_number_literal_scanner c_nls_checker u_c_nls_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (scan_out.valid),
  .out_ready (scan_out.ready),
  .consumed  (scan_out.consumed),
  .done_res  (scan_out.done_res),
  .status    (scan_out.status),
  .length    (scan_out.length)
);

`default_nettype wire
